// ----- rtl/xmodem_crc_receiver_top_assert.svh -----
// Assertion macros shared by the receiver modules.
`ifndef XMODEM_CRC_RECEIVER_TOP_ASSERT_SVH
`define XMODEM_CRC_RECEIVER_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define XCR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, checked outside reset.
`define XCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define XCR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define XCR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/xcr_pkg.sv -----
// Shared constants and types of the XMODEM-CRC receiver.
package xcr_pkg;

  // Buffer geometry
  localparam int BUF_BYTES = 1024;
  localparam int BUF_AW    = $clog2(BUF_BYTES);
  localparam int SHORT_LEN = 128;

  // Register reset values
  localparam logic [23:0] TIMEOUT_RST = 24'd250000;
  localparam logic [7:0]  RETRIES_RST = 8'd200;

  // Input kinds
  localparam logic [2:0] KIND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_TICK  = 3'd1;
  localparam logic [2:0] KIND_START = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_ABORT = 3'd4;

  // Line control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_SUB = 8'h1A;
  localparam logic [7:0] CH_C   = 8'h43;

  // Event codes
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_OK       = 4'd1;
  localparam logic [3:0] EV_DUP      = 4'd2;
  localparam logic [3:0] EV_TIMEOUT  = 4'd3;
  localparam logic [3:0] EV_FRAMING  = 4'd4;
  localparam logic [3:0] EV_CRC      = 4'd5;
  localparam logic [3:0] EV_SEQUENCE = 4'd6;
  localparam logic [3:0] EV_EOF      = 4'd7;
  localparam logic [3:0] EV_CANCEL   = 4'd8;
  localparam logic [3:0] EV_GAVE_UP  = 4'd9;

  // Results of one item: a first result, an optional second one, or the
  // fixed abort burst of four CAN and four BS.
  typedef struct packed {
    logic [3:0]  count;
    logic        abort;
    logic        txv0;
    logic [7:0]  tx0;
    logic        dv0;
    logic [3:0]  ev0;
    logic [10:0] len0;
    logic        txv1;
    logic [7:0]  tx1;
    logic [3:0]  ev1;
  } res_t;

  // Buffer access of one item
  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [BUF_AW-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/xcr_regs.sv -----
// APB configuration registers: character timeout and retry limit.
module xcr_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [23:0] char_timeout,
  output logic [7:0]  max_retries
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // Register writes, decoded on the word address bit
  always_ff @(posedge clk) begin
    if (rst) begin
      char_timeout <= xcr_pkg::TIMEOUT_RST;
      max_retries  <= xcr_pkg::RETRIES_RST;
    end else if (wr) begin
      if (paddr[2]) begin
        max_retries <= pwdata[7:0];
      end else begin
        char_timeout <= pwdata[23:0];
      end
    end
  end

  // Read-back
  always_comb begin
    if (paddr[2]) begin
      prdata = {24'd0, max_retries};
    end else begin
      prdata = {8'd0, char_timeout};
    end
  end

endmodule

// ----- rtl/xcr_buf.sv -----
// Block payload buffer: one write port, one registered read port.
module xcr_buf (
  input  logic               clk,
  input  xcr_pkg::mem_req_t  req,
  output logic [7:0]         rdata
);

  logic [7:0] mem [xcr_pkg::BUF_BYTES];

  // Payload write
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- rtl/xcr_ctrl.sv -----
// Receiver protocol engine: header parse, CRC, pad tracking, retries.
module xcr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [2:0]         kind,
  input  logic [7:0]         rx_byte,
  input  logic [23:0]        char_timeout,
  input  logic [7:0]         max_retries,
  output xcr_pkg::mem_req_t  mem_req,
  output xcr_pkg::res_t      res
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_HDR    = 4'd1;
  localparam logic [3:0] PH_BNUM   = 4'd2;
  localparam logic [3:0] PH_BCMP   = 4'd3;
  localparam logic [3:0] PH_DATA   = 4'd4;
  localparam logic [3:0] PH_CRCH   = 4'd5;
  localparam logic [3:0] PH_CRCL   = 4'd6;
  localparam logic [3:0] PH_DRAIN  = 4'd7;
  localparam logic [3:0] PH_EOF    = 4'd8;
  localparam logic [3:0] PH_CANCEL = 4'd9;
  localparam logic [3:0] PH_FAIL   = 4'd10;
  localparam logic [3:0] PH_ABORT  = 4'd11;

  logic [3:0]  phase, phase_next;
  logic        long_block, long_block_next;
  logic [7:0]  block_number, block_number_next;
  logic [7:0]  block_complement, block_complement_next;
  logic [7:0]  expected_block, expected_block_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic [10:0] byte_index, byte_index_next;
  logic [10:0] last_nonpad_end, last_nonpad_end_next;
  logic [1:0]  trailing_pads, trailing_pads_next;
  logic [10:0] bytes_left, bytes_left_next;
  logic [9:0]  read_pointer, read_pointer_next;
  logic [1:0]  cancel_count, cancel_count_next;
  logic        first_header_char, first_header_char_next;
  logic [7:0]  retries_left, retries_left_next;
  logic [23:0] idle_ticks, idle_ticks_next;
  logic        ack_pending, ack_pending_next;

  // Shared combinational terms
  logic [10:0] full_len;
  logic [10:0] index_inc;
  logic [10:0] kept_len;
  logic [7:0]  crc_s;
  logic [15:0] crc_t;
  logic [15:0] crc_upd;
  logic [15:0] crc_rx;
  logic [23:0] ticks_inc;
  logic [10:0] left_dec;

  assign full_len  = long_block ? 11'(xcr_pkg::BUF_BYTES) : 11'(xcr_pkg::SHORT_LEN);
  assign index_inc = byte_index + 11'd1;
  assign kept_len  = (trailing_pads == 2'd3) ? last_nonpad_end : full_len;
  assign crc_rx    = {received_crc[15:8], rx_byte};
  assign ticks_inc = (idle_ticks == 24'hFFFFFF) ? idle_ticks : idle_ticks + 24'd1;
  assign left_dec  = bytes_left - 11'd1;

  // CRC-16/XMODEM, one byte per step
  always_comb begin
    crc_s   = rx_byte ^ running_crc[15:8];
    crc_t   = {8'd0, crc_s ^ {4'd0, crc_s[7:4]}};
    crc_upd = {running_crc[7:0], 8'd0} ^ crc_t ^ (crc_t << 5) ^ (crc_t << 12);
  end

  // Next state and results of the item being taken
  always_comb begin
    logic attempt;
    logic new_block;
    phase_next             = phase;
    long_block_next        = long_block;
    block_number_next      = block_number;
    block_complement_next  = block_complement;
    expected_block_next    = expected_block;
    running_crc_next       = running_crc;
    received_crc_next      = received_crc;
    byte_index_next        = byte_index;
    last_nonpad_end_next   = last_nonpad_end;
    trailing_pads_next     = trailing_pads;
    bytes_left_next        = bytes_left;
    read_pointer_next      = read_pointer;
    cancel_count_next      = cancel_count;
    first_header_char_next = first_header_char;
    retries_left_next      = retries_left;
    idle_ticks_next        = idle_ticks;
    ack_pending_next       = ack_pending;
    res                    = '0;
    mem_req                = '0;
    mem_req.waddr          = byte_index[xcr_pkg::BUF_AW-1:0];
    mem_req.wdata          = rx_byte;
    mem_req.raddr          = read_pointer;
    attempt                = 1'b0;
    new_block              = 1'b0;

    unique case (kind)
      xcr_pkg::KIND_BYTE: begin
        idle_ticks_next = '0;
        unique case (phase)
          PH_HDR: begin
            first_header_char_next = 1'b0;
            if (rx_byte == xcr_pkg::CH_SOH || rx_byte == xcr_pkg::CH_STX) begin
              long_block_next = (rx_byte == xcr_pkg::CH_STX);
              phase_next      = PH_BNUM;
            end else if (rx_byte == xcr_pkg::CH_CAN) begin
              if (cancel_count == 2'd2) begin
                cancel_count_next = '0;
                phase_next        = PH_CANCEL;
                res.count         = 4'd1;
                res.ev0           = xcr_pkg::EV_CANCEL;
              end else begin
                cancel_count_next = cancel_count + 2'd1;
              end
            end else if (rx_byte == xcr_pkg::CH_EOT && first_header_char) begin
              res.count  = 4'd2;
              res.txv0   = 1'b1;
              res.tx0    = xcr_pkg::CH_ACK;
              res.ev0    = xcr_pkg::EV_EOF;
              res.txv1   = 1'b1;
              res.tx1    = xcr_pkg::CH_ACK;
              res.ev1    = xcr_pkg::EV_NONE;
              phase_next = PH_EOF;
            end
          end
          PH_BNUM: begin
            block_number_next = rx_byte;
            phase_next        = PH_BCMP;
          end
          PH_BCMP: begin
            block_complement_next = rx_byte;
            phase_next            = PH_DATA;
            byte_index_next       = '0;
            running_crc_next      = '0;
            trailing_pads_next    = '0;
            last_nonpad_end_next  = '0;
          end
          PH_DATA: begin
            mem_req.we       = 1'b1;
            running_crc_next = crc_upd;
            if (rx_byte == xcr_pkg::CH_SUB) begin
              if (trailing_pads != 2'd3) begin
                trailing_pads_next = trailing_pads + 2'd1;
              end
            end else begin
              trailing_pads_next   = '0;
              last_nonpad_end_next = index_inc;
            end
            byte_index_next = index_inc;
            if (index_inc >= full_len) begin
              phase_next = PH_CRCH;
            end
          end
          PH_CRCH: begin
            received_crc_next = {rx_byte, 8'd0};
            phase_next        = PH_CRCL;
          end
          PH_CRCL: begin
            received_crc_next = crc_rx;
            res.count         = 4'd1;
            priority if ((block_number ^ block_complement) != 8'hFF) begin
              res.txv0 = 1'b1;
              res.tx0  = xcr_pkg::CH_C;
              res.ev0  = xcr_pkg::EV_FRAMING;
              attempt  = 1'b1;
            end else if (running_crc != crc_rx) begin
              res.txv0 = 1'b1;
              res.tx0  = xcr_pkg::CH_C;
              res.ev0  = xcr_pkg::EV_CRC;
              attempt  = 1'b1;
            end else if (block_number == expected_block) begin
              expected_block_next = expected_block + 8'd1;
              bytes_left_next     = kept_len;
              read_pointer_next   = '0;
              res.ev0             = xcr_pkg::EV_OK;
              if (kept_len == 11'd0) begin
                ack_pending_next = 1'b0;
                res.txv0         = 1'b1;
                res.tx0          = xcr_pkg::CH_ACK;
                new_block        = 1'b1;
              end else begin
                ack_pending_next = 1'b1;
                res.len0         = kept_len;
                phase_next       = PH_DRAIN;
              end
            end else if (block_number == expected_block - 8'd1) begin
              res.txv0 = 1'b1;
              res.tx0  = xcr_pkg::CH_ACK;
              res.ev0  = xcr_pkg::EV_DUP;
              attempt  = 1'b1;
            end else begin
              res.txv0 = 1'b1;
              res.tx0  = xcr_pkg::CH_C;
              res.ev0  = xcr_pkg::EV_SEQUENCE;
              attempt  = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      xcr_pkg::KIND_TICK: begin
        if (phase >= PH_HDR && phase <= PH_CRCL) begin
          idle_ticks_next = ticks_inc;
          if (ticks_inc >= char_timeout) begin
            idle_ticks_next = '0;
            res.count       = 4'd1;
            res.txv0        = 1'b1;
            res.tx0         = xcr_pkg::CH_C;
            res.ev0         = xcr_pkg::EV_TIMEOUT;
            attempt         = 1'b1;
          end
        end
      end
      xcr_pkg::KIND_START: begin
        expected_block_next = 8'd1;
        bytes_left_next     = '0;
        read_pointer_next   = '0;
        ack_pending_next    = 1'b0;
        res.count           = 4'd1;
        res.txv0            = 1'b1;
        res.tx0             = xcr_pkg::CH_C;
        new_block           = 1'b1;
      end
      xcr_pkg::KIND_READ: begin
        if (ack_pending && bytes_left != 11'd0) begin
          mem_req.re        = 1'b1;
          read_pointer_next = read_pointer + 10'd1;
          bytes_left_next   = left_dec;
          res.count         = 4'd1;
          res.dv0           = 1'b1;
          if (left_dec == 11'd0) begin
            ack_pending_next = 1'b0;
            res.txv0         = 1'b1;
            res.tx0          = xcr_pkg::CH_ACK;
            new_block        = 1'b1;
          end
        end
      end
      xcr_pkg::KIND_ABORT: begin
        res.count        = 4'd8;
        res.abort        = 1'b1;
        phase_next       = PH_ABORT;
        bytes_left_next  = '0;
        ack_pending_next = 1'b0;
      end
      default: begin
      end
    endcase

    // One header attempt used; give up when none is left
    if (attempt) begin
      if (retries_left <= 8'd1) begin
        retries_left_next = '0;
        phase_next        = PH_FAIL;
        res.count         = 4'd2;
        res.ev1           = xcr_pkg::EV_GAVE_UP;
      end else begin
        retries_left_next      = retries_left - 8'd1;
        phase_next             = PH_HDR;
        cancel_count_next      = '0;
        first_header_char_next = 1'b1;
        idle_ticks_next        = '0;
      end
    end

    // Fresh header search with a full attempt budget
    if (new_block) begin
      retries_left_next      = max_retries;
      phase_next             = PH_HDR;
      cancel_count_next      = '0;
      first_header_char_next = 1'b1;
      idle_ticks_next        = '0;
    end

    if (!take) begin
      res     = '0;
      mem_req.we = 1'b0;
      mem_req.re = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      long_block        <= 1'b0;
      block_number      <= '0;
      block_complement  <= '0;
      expected_block    <= 8'd1;
      running_crc       <= '0;
      received_crc      <= '0;
      byte_index        <= '0;
      last_nonpad_end   <= '0;
      trailing_pads     <= '0;
      bytes_left        <= '0;
      read_pointer      <= '0;
      cancel_count      <= '0;
      first_header_char <= 1'b1;
      retries_left      <= '0;
      idle_ticks        <= '0;
      ack_pending       <= 1'b0;
    end else if (take) begin
      phase             <= phase_next;
      long_block        <= long_block_next;
      block_number      <= block_number_next;
      block_complement  <= block_complement_next;
      expected_block    <= expected_block_next;
      running_crc       <= running_crc_next;
      received_crc      <= received_crc_next;
      byte_index        <= byte_index_next;
      last_nonpad_end   <= last_nonpad_end_next;
      trailing_pads     <= trailing_pads_next;
      bytes_left        <= bytes_left_next;
      read_pointer      <= read_pointer_next;
      cancel_count      <= cancel_count_next;
      first_header_char <= first_header_char_next;
      retries_left      <= retries_left_next;
      idle_ticks        <= idle_ticks_next;
      ack_pending       <= ack_pending_next;
    end
  end

`include "xmodem_crc_receiver_top_assert.svh"

  // A pending ACK exists exactly while a buffered block drains
  `XCR_ASSERT_IMPLY(a_ack_drain, clk, rst, ack_pending, phase == PH_DRAIN)
  `XCR_ASSERT_IMPLY(a_drain_ack, clk, rst, phase == PH_DRAIN, ack_pending)
  // Draining never sits on an empty buffer
  `XCR_ASSERT_IMPLY(a_drain_left, clk, rst, phase == PH_DRAIN, bytes_left != 11'd0)
  // Payload index never passes the block size while receiving data
  `XCR_ASSERT_IMPLY(a_index_range, clk, rst, phase == PH_DATA, byte_index < full_len)

endmodule

// ----- rtl/xcr_out.sv -----
// Result register: holds one item's results and sends them one per cycle while m_tready is high.
module xcr_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  xcr_pkg::res_t  res_in,
  input  logic [7:0]     rdata,
  output logic           free,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [39:0]    m_tdata,
  output logic           m_tlast
);

  xcr_pkg::res_t held;
  logic          valid;
  logic [2:0]    idx;
  logic          is_last;
  logic          done;
  logic          txv;
  logic [7:0]    tx;
  logic          dv;
  logic [7:0]    dbyte;
  logic [3:0]    ev;
  logic [10:0]   len;

  assign is_last = ({1'b0, idx} == held.count - 4'd1);
  assign done    = valid & m_tready & is_last;
  assign free    = ~valid | done;

  // Holding register and result index
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load && res_in.count != 4'd0) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (done) begin
      valid <= 1'b0;
    end else if (valid && m_tready) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res_in;
    end
  end

  // Select the fields of the current result
  always_comb begin
    txv   = 1'b0;
    tx    = '0;
    dv    = 1'b0;
    dbyte = '0;
    ev    = xcr_pkg::EV_NONE;
    len   = '0;
    priority if (held.abort) begin
      txv = 1'b1;
      tx  = idx[2] ? xcr_pkg::CH_BS : xcr_pkg::CH_CAN;
    end else if (idx == 3'd0) begin
      txv   = held.txv0;
      tx    = held.tx0;
      dv    = held.dv0;
      dbyte = held.dv0 ? rdata : 8'd0;
      ev    = held.ev0;
      len   = held.len0;
    end else begin
      txv = held.txv1;
      tx  = held.tx1;
      ev  = held.ev1;
    end
  end

  assign m_tvalid = valid;
  assign m_tlast  = is_last;
  assign m_tdata  = {7'd0, len, ev, dbyte, dv, tx, txv};

`include "xmodem_crc_receiver_top_assert.svh"

  // A held item always has results left to send
  `XCR_ASSERT_IMPLY(a_count_nz, clk, rst, valid, held.count != 4'd0)
  `XCR_ASSERT_IMPLY(a_idx_range, clk, rst, valid, {1'b0, idx} < held.count)
  // Abort bursts are always eight long
  `XCR_ASSERT_IMPLY(a_abort_len, clk, rst, valid && held.abort, held.count == 4'd8)
  // A sent last result with nothing loaded leaves the stage empty
  `XCR_ASSERT_NEXT(a_drain_empty, clk, rst, done && !load, !valid)

endmodule

// ----- rtl/xmodem_crc_receiver_top.sv -----
// XMODEM-CRC receiver top level: stream in, stream out, APB registers.
// The first result of an item is registered and appears in the cycle after its transfer.
// One item per cycle while m_tready is high. Results leave one per cycle while m_tready is
// high, so an item with more than one result (up to 8, for abort) holds off the next input
// transfer until its last result is sent.
// Reset (rst, synchronous): control state and registers reset; buffer not cleared.
module xmodem_crc_receiver_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] data_valid, [17:10] data_byte,
  // [21:18] event_res, [32:22] block_length, [39:33] zero
  output logic [39:0] m_tdata,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              take;
  logic [23:0]       char_timeout;
  logic [7:0]        max_retries;
  xcr_pkg::mem_req_t mem_req;
  xcr_pkg::res_t     res;
  logic [7:0]        rdata;
  logic              free;

  assign s_tready = free;
  assign take     = s_tvalid & free;

  xcr_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .char_timeout (char_timeout),
    .max_retries  (max_retries)
  );

  xcr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .kind         (s_tuser),
    .rx_byte      (s_tdata),
    .char_timeout (char_timeout),
    .max_retries  (max_retries),
    .mem_req      (mem_req),
    .res          (res)
  );

  xcr_buf u_buf (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  xcr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res_in   (res),
    .rdata    (rdata),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- tb/tb_xmodem_crc_receiver_top.sv -----
// Self-checking testbench for the XMODEM-CRC receiver top level.
module tb_xmodem_crc_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xcr_pkg::*;

  // Register indexes, byte address is 4 * index
  localparam int REG_TIMEOUT = 0;
  localparam int REG_RETRIES = 1;

  // Item kinds the block ignores
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  localparam int WHOLE_FRAME = BUF_BYTES + 5;
  localparam int PHASE_ITEMS = 22;
  localparam int N_PLANS     = 5;

  // Receiver phases as tracked by the scoreboard
  typedef enum logic [3:0] {
    RX_IDLE, RX_HEADER, RX_BNUM, RX_BCMP, RX_PAYLOAD, RX_CRC_HI, RX_CRC_LO,
    RX_DRAIN, RX_EOF, RX_CANCEL, RX_FAIL, RX_ABORT
  } rx_phase_e;

  // One result transfer on the master side
  typedef struct packed {
    logic        txv;
    logic [7:0]  tx;
    logic        dv;
    logic [7:0]  d;
    logic [3:0]  ev;
    logic [10:0] len;
    logic        last;
  } reply_t;

  // CRC-16/XMODEM, one byte, high bit first
  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [7:0]  s;
    logic [7:0]  t;
    logic [15:0] w;
    s = b ^ c[15:8];
    t = s ^ (s >> 4);
    w = {8'h00, t};
    return {c[7:0], 8'h00} ^ w ^ (w << 5) ^ (w << 12);
  endfunction

  // Receiver model plus the queue of replies still owed by the block
  class xmodem_scoreboard;
    logic [23:0] char_timeout;
    logic [7:0]  retry_limit;
    rx_phase_e   st;
    bit          long_blk;
    logic [7:0]  blk_num;
    logic [7:0]  blk_cmp;
    logic [7:0]  expect_num;
    logic [7:0]  tries_left;
    logic [15:0] crc_acc;
    logic [15:0] crc_rx;
    logic [10:0] pay_idx;
    logic [10:0] nonpad_end;
    logic [10:0] drain_left;
    logic [9:0]  rd_ptr;
    logic [1:0]  pads;
    logic [1:0]  can_cnt;
    bit          hdr_first;
    logic [23:0] quiet_ticks;
    logic [7:0]  payload_mem [BUF_BYTES];
    reply_t      step_replies[$];
    reply_t      awaited[$];
    int          mismatches;

    function new();
      char_timeout = TIMEOUT_RST;
      retry_limit  = RETRIES_RST;
      st           = RX_IDLE;
      long_blk     = 1'b0;
      blk_num      = '0;
      blk_cmp      = '0;
      expect_num   = 8'd1;
      tries_left   = '0;
      crc_acc      = '0;
      crc_rx       = '0;
      pay_idx      = '0;
      nonpad_end   = '0;
      drain_left   = '0;
      rd_ptr       = '0;
      pads         = '0;
      can_cnt      = '0;
      hdr_first    = 1'b1;
      quiet_ticks  = '0;
      mismatches   = 0;
    endfunction

    function void set_register(int idx, logic [31:0] value);
      if (idx == REG_TIMEOUT) char_timeout = value[23:0];
      else if (idx == REG_RETRIES) retry_limit = value[7:0];
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void add_reply(bit txv, logic [7:0] tx, bit dv, logic [7:0] d,
                            logic [3:0] ev, logic [10:0] len);
      reply_t r;
      r.txv = txv; r.tx = tx; r.dv = dv; r.d = d; r.ev = ev; r.len = len;
      r.last = 1'b0;
      step_replies.push_back(r);
    endfunction

    function void open_header();
      st = RX_HEADER;
      can_cnt = '0;
      hdr_first = 1'b1;
      quiet_ticks = '0;
    endfunction

    function void open_block();
      tries_left = retry_limit;
      open_header();
    endfunction

    // one attempt used; the block fails when none is left
    function void spend_attempt();
      if (tries_left <= 8'd1) begin
        tries_left = '0;
        st = RX_FAIL;
        add_reply(1'b0, 8'h00, 1'b0, 8'h00, EV_GAVE_UP, 11'd0);
      end else begin
        tries_left--;
        open_header();
      end
    endfunction

    function void reject(logic [3:0] code);
      add_reply(1'b1, CH_C, 1'b0, 8'h00, code, 11'd0);
      spend_attempt();
    endfunction

    // framing, then CRC, then sequence
    function void close_block();
      logic [10:0] full;
      logic [10:0] kept;
      full = long_blk ? 11'(BUF_BYTES) : 11'(SHORT_LEN);
      if ((blk_num ^ blk_cmp) != 8'hFF) begin
        reject(EV_FRAMING);
      end else if (crc_acc != crc_rx) begin
        reject(EV_CRC);
      end else if (blk_num == expect_num) begin
        expect_num++;
        kept = (pads == 2'd3) ? nonpad_end : full;
        drain_left = kept;
        rd_ptr = '0;
        if (kept == 11'd0) begin
          add_reply(1'b1, CH_ACK, 1'b0, 8'h00, EV_OK, 11'd0);
          open_block();
        end else begin
          add_reply(1'b0, 8'h00, 1'b0, 8'h00, EV_OK, kept);
          st = RX_DRAIN;
        end
      end else if (blk_num == 8'(expect_num - 8'd1)) begin
        add_reply(1'b1, CH_ACK, 1'b0, 8'h00, EV_DUP, 11'd0);
        spend_attempt();
      end else begin
        reject(EV_SEQUENCE);
      end
    endfunction

    function void line_byte(logic [7:0] b);
      bit          was_first;
      logic [10:0] full;
      quiet_ticks = '0;
      case (st)
        RX_HEADER: begin
          was_first = hdr_first;
          hdr_first = 1'b0;
          if (b == CH_SOH || b == CH_STX) begin
            long_blk = (b == CH_STX);
            st = RX_BNUM;
          end else if (b == CH_CAN) begin
            can_cnt++;
            if (can_cnt == 2'd3) begin
              can_cnt = '0;
              st = RX_CANCEL;
              add_reply(1'b0, 8'h00, 1'b0, 8'h00, EV_CANCEL, 11'd0);
            end
          end else if (b == CH_EOT && was_first) begin
            add_reply(1'b1, CH_ACK, 1'b0, 8'h00, EV_EOF, 11'd0);
            add_reply(1'b1, CH_ACK, 1'b0, 8'h00, EV_NONE, 11'd0);
            st = RX_EOF;
          end
        end
        RX_BNUM: begin
          blk_num = b;
          st = RX_BCMP;
        end
        RX_BCMP: begin
          blk_cmp = b;
          st = RX_PAYLOAD;
          pay_idx = '0;
          crc_acc = '0;
          pads = '0;
          nonpad_end = '0;
        end
        RX_PAYLOAD: begin
          full = long_blk ? 11'(BUF_BYTES) : 11'(SHORT_LEN);
          payload_mem[pay_idx[9:0]] = b;
          crc_acc = crc16_step(crc_acc, b);
          // pad run saturates at three
          if (b == CH_SUB) begin
            if (pads != 2'd3) pads++;
          end else begin
            pads = '0;
            nonpad_end = pay_idx + 11'd1;
          end
          pay_idx++;
          if (pay_idx >= full) st = RX_CRC_HI;
        end
        RX_CRC_HI: begin
          crc_rx = {b, 8'h00};
          st = RX_CRC_LO;
        end
        RX_CRC_LO: begin
          crc_rx[7:0] = b;
          close_block();
        end
        default: ;
      endcase
    endfunction

    // input transfer accepted: queue the replies it causes
    function void accept_item(logic [2:0] kind, logic [7:0] b);
      logic [7:0] d;
      reply_t     r;
      step_replies.delete();
      case (kind)
        KIND_BYTE: line_byte(b);
        KIND_TICK: begin
          if (st >= RX_HEADER && st <= RX_CRC_LO) begin
            if (quiet_ticks != 24'hFFFFFF) quiet_ticks++;
            if (quiet_ticks >= char_timeout) begin
              quiet_ticks = '0;
              reject(EV_TIMEOUT);
            end
          end
        end
        KIND_START: begin
          expect_num = 8'd1;
          drain_left = '0;
          rd_ptr = '0;
          add_reply(1'b1, CH_C, 1'b0, 8'h00, EV_NONE, 11'd0);
          open_block();
        end
        KIND_READ: begin
          if (st == RX_DRAIN && drain_left != 11'd0) begin
            d = payload_mem[rd_ptr];
            rd_ptr++;
            drain_left--;
            // the final byte carries the ACK
            if (drain_left == 11'd0) begin
              add_reply(1'b1, CH_ACK, 1'b1, d, EV_NONE, 11'd0);
              open_block();
            end else begin
              add_reply(1'b0, 8'h00, 1'b1, d, EV_NONE, 11'd0);
            end
          end
        end
        KIND_ABORT: begin
          repeat (4) add_reply(1'b1, CH_CAN, 1'b0, 8'h00, EV_NONE, 11'd0);
          repeat (4) add_reply(1'b1, CH_BS, 1'b0, 8'h00, EV_NONE, 11'd0);
          st = RX_ABORT;
          drain_left = '0;
        end
        default: ;
      endcase
      if (step_replies.size() != 0) begin
        r = step_replies.pop_back();
        r.last = 1'b1;
        step_replies.push_back(r);
      end
      foreach (step_replies[i]) awaited.push_back(step_replies[i]);
    endfunction

    function void flag(string what, reply_t want, reply_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: exp tx %0b/%h data %0b/%h ev %0d len %0d last %0b",
                 $time, what, want.txv, want.tx, want.dv, want.d, want.ev,
                 want.len, want.last,
                 "; got tx %0b/%h data %0b/%h ev %0d len %0d last %0b",
                 got.txv, got.tx, got.dv, got.d, got.ev, got.len, got.last);
    endfunction

    // result transfer seen: compare with the oldest owed reply
    function void check_reply(logic [39:0] data, logic last);
      reply_t got;
      reply_t want;
      got.txv = data[0];
      got.tx = data[8:1];
      got.dv = data[9];
      got.d = data[17:10];
      got.ev = data[21:18];
      got.len = data[32:22];
      got.last = last;
      if (awaited.size() == 0) begin
        flag("reply with none owed", got, got);
      end else begin
        want = awaited.pop_front();
        if (got.txv !== want.txv || got.tx !== want.tx || got.dv !== want.dv ||
            got.d !== want.d || got.ev !== want.ev || got.len !== want.len ||
            got.last !== want.last)
          flag("reply mismatch", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] rx_byte
  logic [2:0]  s_tuser;   // [2:0] kind
  logic        m_tvalid;
  logic        m_tready;
  // [0] tx_valid, [8:1] tx_byte, [9] data_valid, [17:10] data_byte,
  // [21:18] event_res, [32:22] block_length
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  xmodem_scoreboard sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int items_sent = 0;

  // register settings per test phase: extremes, zeros and short timeouts
  logic [23:0] timeout_plan [0:N_PLANS-1] = '{24'd3, 24'd1, 24'hFFFFFF, 24'd0, 24'd6};
  logic [7:0]  retries_plan [0:N_PLANS-1] = '{8'd4, 8'd1, 8'd255, 8'd0, 8'd2};

  xmodem_crc_receiver_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // one input transfer, after a random gap
  task automatic send_item(logic [2:0] kind, logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.accept_item(kind, b);
    items_sent++;
    if ($urandom_range(0, 59) == 0) tx_idle_on = !tx_idle_on;
  endtask

  // hold input off until every owed reply is back, then let the block settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup phase, access phase, then the bus returns to idle
  task automatic apb_write(int idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(KIND_TICK, any_byte());
  endtask

  // block frame; only the first keep bytes go out
  task automatic send_frame(bit long_blk, logic [7:0] num, logic [7:0] cmp,
                            int pads, bit bad_crc, int keep);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    logic [7:0]  b;
    int          full;
    int          i;
    full = long_blk ? BUF_BYTES : SHORT_LEN;
    crc = 16'h0000;
    frame.push_back(long_blk ? CH_STX : CH_SOH);
    frame.push_back(num);
    frame.push_back(cmp);
    for (i = 0; i < full; i++) begin
      if (i >= full - pads) b = CH_SUB;
      else if ($urandom_range(0, 15) == 0) b = CH_SUB;
      else b = any_byte();
      crc = crc16_step(crc, b);
      frame.push_back(b);
    end
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    for (i = 0; i < keep && i < frame.size(); i++) send_item(KIND_BYTE, frame[i]);
  endtask

  // read out the buffered block, with ignored noise mixed in
  task automatic drain_buffer(bit may_break);
    int r;
    while (sb.st == RX_DRAIN) begin
      r = $urandom_range(0, 199);
      if (r < 180) send_item(KIND_READ, any_byte());
      else if (r < 188) send_item(KIND_TICK, any_byte());
      else if (r < 196 || !may_break) send_item(KIND_BYTE, any_byte());
      else if (r < 198) send_item(KIND_START, any_byte());
      else send_item(KIND_ABORT, any_byte());
    end
  endtask

  // good block with a long pad tail, so the read-out stays short
  task automatic good_block(bit long_blk, bit may_break);
    int full;
    int pads;
    int r;
    full = long_blk ? BUF_BYTES : SHORT_LEN;
    r = $urandom_range(0, 9);
    if (r < 2) pads = full;
    else pads = $urandom_range(full / 2 - 4, full - 4);
    send_frame(long_blk, sb.expect_num, ~sb.expect_num, pads, 1'b0, WHOLE_FRAME);
    drain_buffer(may_break);
  endtask

  // one step of random traffic, shaped by where the receiver stands
  task automatic run_scenario();
    int         r;
    logic [7:0] num;
    logic [7:0] cmp;
    r = $urandom_range(0, 99);
    if (sb.st == RX_DRAIN) begin
      drain_buffer(1'b1);
    end else if (sb.st == RX_HEADER) begin
      if (r < 30) begin
        // frame cut short, then the line goes quiet
        num = ($urandom_range(0, 2) == 0) ? any_byte() : sb.expect_num;
        cmp = ($urandom_range(0, 3) == 0) ? any_byte() : ~num;
        send_frame(1'($urandom_range(0, 1)), num, cmp, 0, 1'b0, $urandom_range(1, 12));
        send_ticks($urandom_range(1, 8));
      end else if (r < 42) begin
        send_ticks($urandom_range(1, 12));
      end else if (r < 52) begin
        send_item(KIND_BYTE, CH_CAN);
        if ($urandom_range(0, 1) == 0) send_item(KIND_BYTE, any_byte());
        send_item(KIND_BYTE, CH_CAN);
        send_item(KIND_BYTE, CH_CAN);
      end else if (r < 62) begin
        send_item(KIND_BYTE, CH_EOT);
      end else if (r < 68) begin
        send_item(KIND_BYTE, any_byte());
        send_item(KIND_BYTE, CH_EOT);
      end else if (r < 74) begin
        send_item(KIND_ABORT, any_byte());
      end else if (r < 82) begin
        send_item(KIND_START, any_byte());
      end else if (r < 90) begin
        send_item(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), any_byte());
      end else begin
        send_item(KIND_READ, any_byte());
      end
    end else if (sb.st >= RX_BNUM && sb.st <= RX_CRC_LO) begin
      if (r < 60) send_item(KIND_START, any_byte());
      else if (r < 80) send_ticks($urandom_range(1, 4));
      else send_item(KIND_BYTE, any_byte());
    end else begin
      if (r < 75) send_item(KIND_START, any_byte());
      else if (r < 82) send_item(KIND_BYTE, any_byte());
      else if (r < 88) send_item(KIND_TICK, any_byte());
      else if (r < 94) send_item(KIND_READ, any_byte());
      else send_item(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), any_byte());
    end
  endtask

  // result side: random stalls, check every transfer
  initial begin
    int gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_reply(m_tdata, m_tlast);
      if ($urandom_range(0, 49) == 0) rx_idle_on = !rx_idle_on;
    end
  end

  // stimulus
  initial begin
    int p;
    int base;
    sb = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= KIND_BYTE;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= 3'd0;
    pwdata   <= 32'h0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ignored kinds, idle traffic, EOT first and not first, cancel, abort
    send_item(KIND_UNUSED_LO, 8'hFF);
    send_item(KIND_UNUSED_LO + 3'd1, 8'h00);
    send_item(KIND_UNUSED_HI, 8'hA5);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_START, 8'h00);
    send_item(KIND_BYTE, CH_EOT);
    send_item(KIND_START, 8'hFF);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, CH_EOT);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, CH_CAN);
    send_item(KIND_BYTE, CH_CAN);
    send_item(KIND_BYTE, CH_CAN);
    send_item(KIND_READ, 8'hFF);
    send_item(KIND_START, 8'h00);
    send_item(KIND_ABORT, 8'h00);
    send_item(KIND_START, 8'h00);

    // random phases, registers rewritten while nothing is owed
    for (p = 0; p < N_PLANS; p++) begin
      wait_drained();
      apb_write(REG_TIMEOUT, {8'h00, timeout_plan[p]});
      apb_write(REG_RETRIES, {24'h0, retries_plan[p]});
      if (timeout_plan[p] == 24'hFFFFFF) begin
        // one short block, read out in full
        send_item(KIND_START, any_byte());
        good_block(1'b0, 1'b0);
      end
      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) run_scenario();
    end

    wait_drained();
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/xcr_pkg.sv
rtl/xcr_regs.sv
rtl/xcr_buf.sv
rtl/xcr_ctrl.sv
rtl/xcr_out.sv
rtl/xmodem_crc_receiver_top.sv
tb/tb_xmodem_crc_receiver_top.sv
